FILE: rtl/gps_pkg.sv
// shared constants, types and the window table generator of the pitch shifter
package gps_pkg;

    localparam int MAX_GRAIN_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 12;

    // increment field is unsigned q4.12
    localparam int INC_W    = 16;
    localparam int INC_FRAC = 12;

    // grain length register
    localparam int GLOG_W   = 4;
    localparam int GLOG_MIN = 3;
    localparam int GLOG_RST = 11;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // window table, unsigned q1.15
    localparam int WIN_W    = 16;
    localparam int WIN_FRAC = 15;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAIN_LOG2 = 1'b0,
        REG_MUTE       = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    // per-step strobes from the sequencer to the interpolate and sum unit
    typedef struct packed {
        logic clr;
        logic a_lat;
        logic v_en;
        logic prod_en;
        logic acc_en;
    } t_mac_ctl;

    // hann window entry sin^2(pi*i/n) in q1.15, n = 2^lg, evaluated at elaboration
    function automatic logic [WIN_W-1:0] win_value(input int unsigned idx,
                                                   input int unsigned lg);
        logic [63:0] full;
        logic [63:0] half;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] sq;
        full = 64'd1 << lg;
        half = full >> 1;
        u    = (64'(idx) <= half) ? 64'(idx) : full - 64'(idx);
        x    = (u * PI_Q30) >> lg;
        x2   = (x * x) >> 30;
        t    = Q30_ONE - x2 / 64'd110;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s    = (x * t) >> 30;
        sq   = (s * s) >> 30;
        return WIN_W'((sq + (64'd1 << 14)) >> WIN_FRAC);
    endfunction

endpackage

FILE: rtl/gps_in_if.sv
// input channel of the pitch shifter: one audio sample and its read increment
interface gps_in_if
    import gps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [INC_W-1:0]              increment;

    modport source (output valid, output sample_in, output increment, input ready);
    modport sink   (input valid, input sample_in, input increment, output ready);
endinterface

FILE: rtl/gps_out_if.sv
// output channel of the pitch shifter: one summed grain sample
interface gps_out_if
    import gps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/granular_pitch_shifter.sv
// granular pitch shifter top level: sequencer, grain state and store access
//
// each accepted item writes its sample into a circular store of four grain
// lengths, then three grain readers a third of a grain apart each fetch two
// neighbouring samples at their fractional phase, interpolate linearly and
// weight the result by a hann window; the three grains are summed, rounded
// and clipped to one output item. for an unmuted item the accept cycle doubles
// as the store write, then nine sequencer steps carry six back-to-back reads
// on the single read port of the sample store plus the tail of the
// multiply-accumulate, and a finish state loads the output register once it is
// free. a muted item skips to the finish state and returns zero, leaving the
// store, write pointer and grain state untouched. after reset the store is
// swept to zero, one entry per cycle, over all 4*MAX_GRAIN entries (16384 at
// the default size), during which no item is accepted; configuration writes
// are taken throughout. writing grain_log2 (clamped to 3..log2(MAX_GRAIN))
// restarts the write pointer, grain counters and phases but keeps the store
// contents. a zero increment means 0.5. results wait in an output register,
// so the next item is accepted while the previous result is still pending
module granular_pitch_shifter
    import gps_pkg::*;
#(
    parameter int MAX_GRAIN   = MAX_GRAIN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gps_in_if.sink                i_in,
    gps_out_if.source             o_out
);
    // sizes that follow from the grain length limit
    localparam int CNT_W      = $clog2(MAX_GRAIN);
    localparam int AW         = CNT_W + 2;
    localparam int PH_W       = AW + FRAC_BITS;
    localparam int SH_W       = $clog2(CNT_W + 1);
    localparam int GLOG_RST_C = (GLOG_RST > CNT_W) ? CNT_W : GLOG_RST;
    localparam int INC_UP     = (FRAC_BITS >= INC_FRAC) ? FRAC_BITS - INC_FRAC : 0;
    localparam int INC_DN     = (FRAC_BITS < INC_FRAC) ? INC_FRAC - FRAC_BITS : 0;
    localparam int NGRAIN     = 3;

    // sequencer step numbering inside the run state
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;

    // clamp a written grain length to the supported range
    function automatic logic [GLOG_W-1:0] clamp_glog(input logic [GLOG_W-1:0] v);
        logic [GLOG_W-1:0] c;
        if (int'(v) < GLOG_MIN) begin
            c = GLOG_W'(GLOG_MIN);
        end else if (int'(v) > CNT_W) begin
            c = GLOG_W'(CNT_W);
        end else begin
            c = v;
        end
        return c;
    endfunction

    // floor(2^e / 3) is the alternating bit pattern 1010.. of e-1 bits
    function automatic logic [CNT_W-1:0] third_of_pow2(input logic [GLOG_W:0] e);
        logic [CNT_W-1:0] q;
        q = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if ((i + 2 <= int'(e)) && (((int'(e) - i) & 1) == 0)) begin
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // control and configuration registers
    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [AW-1:0]       r_clr_addr;
    logic [GLOG_W-1:0]   r_glog;
    logic                r_mute;
    logic                r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;

    // grain state and per-item values
    logic [AW-1:0]       r_wp;
    logic [CNT_W-1:0]    r_cnt [NGRAIN];
    logic [PH_W-1:0]     r_ph  [NGRAIN];
    logic [PH_W-1:0]     r_inc;

    // handshake and sequencer decode
    logic                in_ready;
    logic                accept;
    logic                out_load;
    logic                run;
    logic [STEP_W-1:0]   stepm1;
    logic [STEP_W-1:0]   stepm3;
    logic [1:0]          rd_k;
    logic                rd_b;
    logic [1:0]          upd_k;
    t_mac_ctl            mac_ctl;

    // configuration decode and grain restart values
    logic                cfg_glog_wr;
    logic [GLOG_W-1:0]   rs_glog;
    logic [CNT_W-1:0]    rs_third1;
    logic [CNT_W-1:0]    rs_third2;

    // derived masks and addresses
    logic [GLOG_W:0]     glog_p2;
    logic [AW-1:0]       bmask;
    logic [PH_W-1:0]     pmask;
    logic [CNT_W:0]      len;
    logic [SH_W-1:0]     shift_amt;
    logic [PH_W-1:0]     rd_ph;
    logic [AW-1:0]       ia;
    logic [AW-1:0]       ib;
    logic [CNT_W-1:0]    upd_cnt;
    logic [PH_W-1:0]     upd_ph;
    logic [CNT_W:0]      cnt1;
    logic                wrap;
    logic [PH_W-1:0]     base;
    logic [PH_W-1:0]     new_ph;
    logic [CNT_W-1:0]    new_cnt;
    logic [INC_W-1:0]    inc_raw;
    logic [PH_W-1:0]     inc_s;

    // store and window access
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [CNT_W-1:0]       win_addr;
    logic [WIN_W-1:0]       win_data;
    logic [SAMPLE_BITS-1:0] mac_sample;

    // configuration writes
    assign cfg_glog_wr = i_cfg_we && (i_cfg_idx == REG_GRAIN_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glog <= GLOG_W'(GLOG_RST_C);
            r_mute <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_GRAIN_LOG2: r_glog <= clamp_glog(i_cfg_data);
                REG_MUTE:       r_mute <= i_cfg_data[0];
            endcase
        end
    end

    // restart values: taken from the reset length or from the value being written
    always_comb begin
        rs_glog   = i_rst_n ? clamp_glog(i_cfg_data) : GLOG_W'(GLOG_RST_C);
        rs_third1 = third_of_pow2({1'b0, rs_glog});
        rs_third2 = third_of_pow2({1'b0, rs_glog} + (GLOG_W+1)'(1));
    end

    // masks for the current grain length: store holds 4L, phases wrap at 4L
    always_comb begin
        glog_p2   = {1'b0, r_glog} + (GLOG_W+1)'(2);
        bmask     = ~({AW{1'b1}} << glog_p2);
        pmask     = ~({PH_W{1'b1}} << (int'(glog_p2) + FRAC_BITS));
        len       = (CNT_W+1)'(1) << r_glog;
        shift_amt = SH_W'(CNT_W) - SH_W'(r_glog);
    end

    // increment: zero means one half, then rescaled to the phase fraction
    always_comb begin
        inc_raw = (i_in.increment == '0) ? INC_W'(1 << (INC_FRAC - 1)) : i_in.increment;
        inc_s   = (PH_W'(inc_raw) << INC_UP) >> INC_DN;
    end

    // step decode: reads of grain k at steps 2k+1 (a) and 2k+2 (b),
    // grain k update and window fetch at 2k+3, product at 2k+4, sum at 2k+5
    always_comb begin
        run    = (r_state == S_RUN);
        stepm1 = r_step - STEP_FIRST;
        stepm3 = r_step - 4'd3;
        rd_k   = stepm1[2:1];
        rd_b   = stepm1[0];
        upd_k  = stepm3[2:1];

        mac_ctl.clr     = accept;
        mac_ctl.a_lat   = run && !r_step[0] && (r_step >= 4'd2) && (r_step <= 4'd6);
        mac_ctl.v_en    = run &&  r_step[0] && (r_step >= 4'd3) && (r_step <= 4'd7);
        mac_ctl.prod_en = run && !r_step[0] && (r_step >= 4'd4) && (r_step <= 4'd8);
        mac_ctl.acc_en  = run &&  r_step[0] && (r_step >= 4'd5) && (r_step <= STEP_LAST);
    end

    // read side: phase of the grain being fetched, neighbour wraps to slot 0
    always_comb begin
        unique case (rd_k)
            2'd0:    rd_ph = r_ph[0];
            2'd1:    rd_ph = r_ph[1];
            default: rd_ph = r_ph[2];
        endcase
        ia        = AW'(rd_ph >> FRAC_BITS) & bmask;
        ib        = (ia + AW'(1)) & bmask;
        ram_raddr = rd_b ? ib : ia;
    end

    // update side: advance counter, jump to the write slot at grain end
    always_comb begin
        unique case (upd_k)
            2'd0: begin
                upd_cnt = r_cnt[0];
                upd_ph  = r_ph[0];
            end
            2'd1: begin
                upd_cnt = r_cnt[1];
                upd_ph  = r_ph[1];
            end
            default: begin
                upd_cnt = r_cnt[2];
                upd_ph  = r_ph[2];
            end
        endcase
        win_addr = CNT_W'(upd_cnt << shift_amt);
        cnt1     = {1'b0, upd_cnt} + (CNT_W+1)'(1);
        wrap     = (cnt1 == len);
        base     = wrap ? (PH_W'(r_wp) << FRAC_BITS) : upd_ph;
        new_ph   = (base + r_inc) & pmask;
        new_cnt  = wrap ? '0 : cnt1[CNT_W-1:0];
    end

    // grain state, write pointer and latched increment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_glog_wr) begin
            r_wp     <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= rs_third1;
            r_cnt[2] <= rs_third2;
            r_ph[0]  <= '0;
            r_ph[1]  <= PH_W'(rs_third1) << FRAC_BITS;
            r_ph[2]  <= PH_W'(rs_third2) << FRAC_BITS;
        end else begin
            if (mac_ctl.v_en) begin
                r_cnt[upd_k] <= new_cnt;
                r_ph[upd_k]  <= new_ph;
            end
            if (run && (r_step == STEP_LAST)) begin
                r_wp <= (r_wp + AW'(1)) & bmask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_inc <= inc_s;
        end
    end

    // sequencer: clearing sweep, idle, run steps, output load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = i_in.sample_in;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    // muted items leave the store and grain state alone and answer zero
                    ram_we  = !r_mute;
                    n_state = r_mute ? S_FINISH : S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    assign accept = i_in.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (accept) begin
                r_step <= STEP_FIRST;
            end else if (run) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // output register parts the sequencer from the downstream side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= mac_sample;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    gps_store_ram #(
        .ADDR_W (AW),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gps_window_rom #(
        .MAX_GRAIN (MAX_GRAIN)
    ) u_window (
        .i_clk  (i_clk),
        .i_addr (win_addr),
        .o_data (win_data)
    );

    gps_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctl     (mac_ctl),
        .i_rd_data ($signed(ram_rdata)),
        .i_frac    (upd_ph[FRAC_BITS-1:0]),
        .i_win     (win_data),
        .o_sample  (mac_sample)
    );

    // one item at a time: ready drops right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in flight");

    // reads in the run state must see a stable store
    a_no_run_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !ram_we)
        else $error("store written during grain reads");

    // grain counters stay inside the current grain length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (({1'b0, r_cnt[0]} < len) && ({1'b0, r_cnt[1]} < len)
                                 && ({1'b0, r_cnt[2]} < len)))
        else $error("grain counter beyond grain length");

    // the last step always hands over to the output load
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (r_step == STEP_LAST)) |=> (r_state == S_FINISH))
        else $error("sequencer overran its last step");
endmodule

FILE: rtl/gps_store_ram.sv
// circular sample store, one write port and one registered read port
module gps_store_ram
    import gps_pkg::*;
#(
    parameter int ADDR_W = 14,
    parameter int DATA_W = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/gps_window_rom.sv
// hann window table with a registered read, filled with constants at elaboration
module gps_window_rom
    import gps_pkg::*;
#(
    parameter int MAX_GRAIN = MAX_GRAIN_DEF
) (
    input  logic                         i_clk,
    input  logic [$clog2(MAX_GRAIN)-1:0] i_addr,
    output logic [WIN_W-1:0]             o_data
);
    localparam int LG = $clog2(MAX_GRAIN);

    logic [WIN_W-1:0] rom_data [MAX_GRAIN];
    logic [WIN_W-1:0] r_data;

    for (genvar g = 0; g < MAX_GRAIN; g++) begin : g_entry
        localparam logic [WIN_W-1:0] W = win_value(g, LG);
        assign rom_data[g] = W;
    end

    always_ff @(posedge i_clk) begin
        r_data <= rom_data[i_addr];
    end

    assign o_data = r_data;
endmodule

FILE: rtl/gps_mac.sv
// linear interpolation, window weighting, grain sum, rounding and saturation
module gps_mac
    import gps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_rd_data,
    input  logic [FRAC_BITS-1:0]          i_frac,
    input  logic [WIN_W-1:0]              i_win,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    localparam int V_W    = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int F_W    = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int P_W    = V_W + WIN_W + 1;
    localparam int ACC_W  = P_W + 2;
    localparam int RND_SH = FRAC_BITS + WIN_FRAC;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
    localparam logic signed [ACC_W-1:0] LIM_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LIM_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [F_W-1:0]         fprod;
    logic signed [V_W-1:0]         v;
    logic signed [V_W-1:0]         r_v;
    logic signed [P_W-1:0]         r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [ACC_W-1:0]       shd;

    // v = a * 2^f + frac * (b - a), b arriving now, a held from the previous read
    always_comb begin
        diff  = $signed({i_rd_data[SAMPLE_BITS-1], i_rd_data})
              - $signed({r_a[SAMPLE_BITS-1], r_a});
        fprod = $signed({1'b0, i_frac}) * diff;
        v     = (V_W'(r_a) <<< FRAC_BITS) + V_W'(fprod);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.a_lat) begin
            r_a <= i_rd_data;
        end
        if (i_ctl.v_en) begin
            r_v <= v;
        end
        if (i_ctl.prod_en) begin
            r_prod <= r_v * $signed({1'b0, i_win});
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, floor shift, clip to the sample range
    always_comb begin
        rnd = r_acc + RND_HALF;
        shd = rnd >>> RND_SH;
        priority if (shd > LIM_HI) begin
            o_sample = SAMPLE_BITS'(LIM_HI);
        end else if (shd < LIM_LO) begin
            o_sample = SAMPLE_BITS'(LIM_LO);
        end else begin
            o_sample = SAMPLE_BITS'(shd);
        end
    end
endmodule
